// ----- rtl/quadratic_root_solver_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the quadratic root solver
// Implication checks sampled on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_UNIT_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_UNIT_ASSERT_SVH

// same-cycle implication
`define QRS_CHECK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define QRS_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/qrs_pkg.sv -----
// ----------------------------------------------------------------------------
// qrs_pkg
// Widths, class codes and saturation for the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COEF_W    = 16;
    localparam int OUT_W     = 34;
    localparam int CLS_W     = 2;

    localparam int S_DATA_W  = 48;
    localparam int M_DATA_W  = 104;

    // square root: root bits, radicand bits, partial remainder bits
    localparam int SQ_W      = FRAC_BITS + 17;
    localparam int RAD_W     = 2 * SQ_W;
    localparam int SREM_W    = SQ_W + 3;

    // numerator and divider widths
    localparam int NB_W      = FRAC_BITS + 17;
    localparam int NUM_W     = FRAC_BITS + 19;
    localparam int NMAG_W    = NUM_W - 1;
    localparam int DEN_W     = 17;
    localparam int DREM_W    = DEN_W + 1;
    localparam int EXT_W     = (NUM_W > OUT_W) ? NUM_W : OUT_W + 1;

    localparam logic [CLS_W-1:0] CLS_NONE   = 2'd0;
    localparam logic [CLS_W-1:0] CLS_TWO    = 2'd1;
    localparam logic [CLS_W-1:0] CLS_DOUBLE = 2'd2;
    localparam logic [CLS_W-1:0] CLS_AZERO  = 2'd3;

    localparam logic signed [EXT_W-1:0] ROOT_MAX_X =
        EXT_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
    localparam logic signed [EXT_W-1:0] ROOT_MIN_X = -ROOT_MAX_X - EXT_W'(1);

    typedef logic [OUT_W-1:0] root_t;

    // apply sign to a quotient magnitude and clamp to the output range
    function automatic root_t sat_root(input logic [NMAG_W-1:0] mag, input logic neg);
        logic signed [NUM_W-1:0] q;
        logic signed [EXT_W-1:0] qx;
        q  = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        qx = EXT_W'(q);
        if (qx > ROOT_MAX_X)
            qx = ROOT_MAX_X;
        else if (qx < ROOT_MIN_X)
            qx = ROOT_MIN_X;
        return qx[OUT_W-1:0];
    endfunction

endpackage

// ----- rtl/quadratic_root_solver_unit.sv -----
// Pipeline: 3 front stages, 33 square-root bit stages, 1 numerator stage,
//   34 divider bit stages, then the output register.
// Throughput: one transaction per cycle while the skid register is empty; each root and divider stage is a bit step.
// Stall: pipeline advances while the output skid register is empty.
// Reset: rst_n asynchronous, clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// quadratic_root_solver_unit
// Discriminant, root class and two Q.16 real roots of a*x^2 + b*x + c.
// ----------------------------------------------------------------------------
`include "quadratic_root_solver_unit_assert.svh"

module quadratic_root_solver_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [qrs_pkg::S_DATA_W-1:0]  s_tdata,   // coef_a, coef_b, coef_c
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [qrs_pkg::M_DATA_W-1:0]  m_tdata,   // discriminant, root_plus, root_minus, pad
    output logic [qrs_pkg::CLS_W-1:0]     m_tuser    // root_class
);
    import qrs_pkg::*;

    logic adv;

    // front stage 1: coefficients
    logic                     v1_reg;
    logic signed [COEF_W-1:0] a1_reg, b1_reg, c1_reg;

    // front stage 2: products
    logic                     v2_reg;
    logic signed [COEF_W-1:0] a2_reg, b2_reg;
    logic signed [31:0]       bb_reg, ac_reg;
    logic signed [31:0]       bb_next, ac_next;

    // front stage 3 comb
    logic signed [OUT_W-1:0]  disc_next;
    logic [CLS_W-1:0]         cls_next;
    logic signed [NB_W-1:0]   nb_ext, nb_next;
    logic [COEF_W:0]          a_ext, a_mag;

    // square-root stages
    logic                     sq_v_reg    [0:SQ_W];
    logic [OUT_W-1:0]         sq_disc_reg [0:SQ_W];
    logic [CLS_W-1:0]         sq_cls_reg  [0:SQ_W];
    logic [NB_W-1:0]          sq_nb_reg   [0:SQ_W];
    logic [DEN_W-1:0]         sq_den_reg  [0:SQ_W];
    logic                     sq_dneg_reg [0:SQ_W];
    logic [RAD_W-1:0]         sq_rad_reg  [0:SQ_W];
    logic [SREM_W-1:0]        sq_rem_reg  [0:SQ_W];
    logic [SQ_W-1:0]          sq_root_reg [0:SQ_W];

    // numerator stage comb
    logic signed [NUM_W-1:0]  num_p, num_m;

    // divider stages, two lanes
    logic                     dv_v_reg    [0:NMAG_W];
    logic [OUT_W-1:0]         dv_disc_reg [0:NMAG_W];
    logic [CLS_W-1:0]         dv_cls_reg  [0:NMAG_W];
    logic [DEN_W-1:0]         dv_den_reg  [0:NMAG_W];
    logic                     dv_negp_reg [0:NMAG_W];
    logic                     dv_negm_reg [0:NMAG_W];
    logic [NMAG_W-1:0]        dv_np_reg   [0:NMAG_W];
    logic [NMAG_W-1:0]        dv_nm_reg   [0:NMAG_W];
    logic [DREM_W-1:0]        dv_rp_reg   [0:NMAG_W];
    logic [DREM_W-1:0]        dv_rm_reg   [0:NMAG_W];

    // result and output buffer
    logic [CLS_W-1:0]         fin_cls;
    logic [OUT_W-1:0]         fin_disc, fin_rp, fin_rm;
    logic                     push, pop;
    logic                     out_v_reg, skid_v_reg;
    logic [CLS_W-1:0]         out_cls_reg, skid_cls_reg;
    logic [3*OUT_W-1:0]       out_dat_reg, skid_dat_reg;

    assign adv      = !skid_v_reg;
    assign s_tready = adv;

    // ---------------- front stages ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
        end
    end

    assign bb_next = b1_reg * b1_reg;
    assign ac_next = a1_reg * c1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_reg <= s_tdata[COEF_W-1:0];
            b1_reg <= s_tdata[2*COEF_W-1:COEF_W];
            c1_reg <= s_tdata[3*COEF_W-1:2*COEF_W];
            a2_reg <= a1_reg;
            b2_reg <= b1_reg;
            bb_reg <= bb_next;
            ac_reg <= ac_next;
        end
    end

    always_comb
    begin
        disc_next = {{2{bb_reg[31]}}, bb_reg} - {ac_reg, 2'b00};
        if (a2_reg == '0)
            cls_next = CLS_AZERO;
        else if (disc_next[OUT_W-1])
            cls_next = CLS_NONE;
        else if (disc_next == '0)
            cls_next = CLS_DOUBLE;
        else
            cls_next = CLS_TWO;
        nb_ext  = {{(NB_W-COEF_W){b2_reg[COEF_W-1]}}, b2_reg};
        nb_next = -(nb_ext <<< FRAC_BITS);
        a_ext   = {a2_reg[COEF_W-1], a2_reg};
        a_mag   = a2_reg[COEF_W-1] ? -a_ext : a_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_v_reg[0] <= 1'b0;
        else if (adv)
            sq_v_reg[0] <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_disc_reg[0] <= disc_next;
            sq_cls_reg[0]  <= cls_next;
            sq_nb_reg[0]   <= nb_next;
            sq_den_reg[0]  <= {a_mag[COEF_W-1:0], 1'b0};
            sq_dneg_reg[0] <= a2_reg[COEF_W-1];
            sq_rad_reg[0]  <= disc_next[OUT_W-1] ? '0 :
                {{(RAD_W-OUT_W+1-2*FRAC_BITS){1'b0}}, disc_next[OUT_W-2:0],
                 {(2*FRAC_BITS){1'b0}}};
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
        end
    end

    // ---------------- square root, one bit per stage ----------------
    for (genvar k = 0; k < SQ_W; k++)
    begin : g_sqrt
        logic [SREM_W-1:0] rem_sh, trial;
        logic              take;

        assign rem_sh = {sq_rem_reg[k][SREM_W-3:0], sq_rad_reg[k][RAD_W-1:RAD_W-2]};
        assign trial  = {1'b0, sq_root_reg[k], 2'b01};
        assign take   = rem_sh >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_v_reg[k+1] <= 1'b0;
            else if (adv)
                sq_v_reg[k+1] <= sq_v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_disc_reg[k+1] <= sq_disc_reg[k];
                sq_cls_reg[k+1]  <= sq_cls_reg[k];
                sq_nb_reg[k+1]   <= sq_nb_reg[k];
                sq_den_reg[k+1]  <= sq_den_reg[k];
                sq_dneg_reg[k+1] <= sq_dneg_reg[k];
                sq_rad_reg[k+1]  <= {sq_rad_reg[k][RAD_W-3:0], 2'b00};
                sq_rem_reg[k+1]  <= take ? rem_sh - trial : rem_sh;
                sq_root_reg[k+1] <= {sq_root_reg[k][SQ_W-2:0], take};
            end
        end
    end

    // ---------------- numerators, sign and magnitude ----------------
    always_comb
    begin
        num_p = NUM_W'($signed(sq_nb_reg[SQ_W])) + $signed({2'b00, sq_root_reg[SQ_W]});
        num_m = NUM_W'($signed(sq_nb_reg[SQ_W])) - $signed({2'b00, sq_root_reg[SQ_W]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_v_reg[0] <= 1'b0;
        else if (adv)
            dv_v_reg[0] <= sq_v_reg[SQ_W];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_disc_reg[0] <= sq_disc_reg[SQ_W];
            dv_cls_reg[0]  <= sq_cls_reg[SQ_W];
            dv_den_reg[0]  <= sq_den_reg[SQ_W];
            dv_negp_reg[0] <= num_p[NUM_W-1] ^ sq_dneg_reg[SQ_W];
            dv_negm_reg[0] <= num_m[NUM_W-1] ^ sq_dneg_reg[SQ_W];
            dv_np_reg[0]   <= num_p[NUM_W-1] ? NMAG_W'(-num_p) : num_p[NMAG_W-1:0];
            dv_nm_reg[0]   <= num_m[NUM_W-1] ? NMAG_W'(-num_m) : num_m[NMAG_W-1:0];
            dv_rp_reg[0]   <= '0;
            dv_rm_reg[0]   <= '0;
        end
    end

    // ---------------- restoring division, one quotient bit per stage ----------------
    for (genvar k = 0; k < NMAG_W; k++)
    begin : g_div
        logic [DREM_W-1:0] shp, shm, dext;
        logic              tp, tm;

        assign dext = {1'b0, dv_den_reg[k]};
        assign shp  = {dv_rp_reg[k][DREM_W-2:0], dv_np_reg[k][NMAG_W-1]};
        assign shm  = {dv_rm_reg[k][DREM_W-2:0], dv_nm_reg[k][NMAG_W-1]};
        assign tp   = shp >= dext;
        assign tm   = shm >= dext;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_v_reg[k+1] <= 1'b0;
            else if (adv)
                dv_v_reg[k+1] <= dv_v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_disc_reg[k+1] <= dv_disc_reg[k];
                dv_cls_reg[k+1]  <= dv_cls_reg[k];
                dv_den_reg[k+1]  <= dv_den_reg[k];
                dv_negp_reg[k+1] <= dv_negp_reg[k];
                dv_negm_reg[k+1] <= dv_negm_reg[k];
                dv_rp_reg[k+1]   <= tp ? shp - dext : shp;
                dv_rm_reg[k+1]   <= tm ? shm - dext : shm;
                dv_np_reg[k+1]   <= {dv_np_reg[k][NMAG_W-2:0], tp};
                dv_nm_reg[k+1]   <= {dv_nm_reg[k][NMAG_W-2:0], tm};
            end
        end
    end

    // ---------------- result assembly ----------------
    always_comb
    begin
        fin_cls  = dv_cls_reg[NMAG_W];
        fin_disc = dv_disc_reg[NMAG_W];
        if (fin_cls == CLS_TWO || fin_cls == CLS_DOUBLE)
        begin
            fin_rp = sat_root(dv_np_reg[NMAG_W], dv_negp_reg[NMAG_W]);
            fin_rm = sat_root(dv_nm_reg[NMAG_W], dv_negm_reg[NMAG_W]);
        end
        else
        begin
            fin_rp = '0;
            fin_rm = '0;
        end
    end

    assign push = adv && dv_v_reg[NMAG_W];
    assign pop  = out_v_reg && m_tready;

    // two-entry output buffer: holding register plus skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_v_reg)
            begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= push;
            end
            else
                out_v_reg  <= push;
        end
        else if (push)
        begin
            if (out_v_reg)
                skid_v_reg <= 1'b1;
            else
                out_v_reg  <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && skid_v_reg)
        begin
            out_cls_reg <= skid_cls_reg;
            out_dat_reg <= skid_dat_reg;
            if (push)
            begin
                skid_cls_reg <= fin_cls;
                skid_dat_reg <= {fin_rm, fin_rp, fin_disc};
            end
        end
        else if (push)
        begin
            if (out_v_reg && !pop)
            begin
                skid_cls_reg <= fin_cls;
                skid_dat_reg <= {fin_rm, fin_rp, fin_disc};
            end
            else
            begin
                out_cls_reg <= fin_cls;
                out_dat_reg <= {fin_rm, fin_rp, fin_disc};
            end
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tuser  = out_cls_reg;
    assign m_tdata  = {{(M_DATA_W-3*OUT_W){1'b0}}, out_dat_reg};

    // ---------------- checks ----------------
    `QRS_CHECK_NOW(a_skid_behind_out, skid_v_reg, out_v_reg, "skid holds data with output empty")
    `QRS_CHECK_NEXT(a_skid_kept, skid_v_reg && !m_tready, skid_v_reg, "skid entry lost while stalled")
    `QRS_CHECK_NOW(a_double_equal, out_v_reg && out_cls_reg == CLS_DOUBLE,
        out_dat_reg[2*OUT_W-1:OUT_W] == out_dat_reg[3*OUT_W-1:2*OUT_W],
        "double root differs between fields")
    `QRS_CHECK_NOW(a_undef_zero, out_v_reg && (out_cls_reg == CLS_NONE || out_cls_reg == CLS_AZERO),
        out_dat_reg[3*OUT_W-1:OUT_W] == '0, "roots not zero for undefined class")

endmodule

// ----- tb/quadratic_root_solver_unit_tb.sv -----
// ----------------------------------------------------------------------------
// quadratic_root_solver_unit_tb
// Streams coefficient sets through the solver with bursty input and a stalling
// output, and checks class, discriminant and both Q.16 roots of every result
// against a behavioural predictor. Directed corner rows come first.
// ----------------------------------------------------------------------------
module quadratic_root_solver_unit_tb;

    import qrs_pkg::*;

    localparam int N_RANDOM = 700;
    localparam int LATENCY  = 71;

    typedef struct packed {
        logic [CLS_W-1:0] cls;
        logic [OUT_W-1:0] disc;
        logic [OUT_W-1:0] rp;
        logic [OUT_W-1:0] rm;
    } solution_t;

    typedef struct {
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] c;
        bit                 typed;   // expected result written in the row
        solution_t          sol;
    } row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;    // coef_a, coef_b, coef_c
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;    // discriminant, root_plus, root_minus, pad
    logic [CLS_W-1:0]     m_tuser;    // root_class

    solution_t pending_solutions[$];
    int        errors;
    int        n_results;
    int        n_sent;
    int        class_seen[4];

    quadratic_root_solver_unit dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // floor(sqrt(d * 2^32)) by bitwise restoring search
    function automatic logic [63:0] scaled_isqrt(input logic [33:0] d);
        logic [127:0] rad;
        logic [63:0]  r;
        logic [63:0]  cand;
        rad = {94'd0, d} << (2 * FRAC_BITS);
        r   = '0;
        for (int i = 43; i >= 0; i--)
        begin
            cand = r | (64'd1 << i);
            if ({64'd0, cand} * {64'd0, cand} <= rad)
                r = cand;
        end
        return r;
    endfunction

    function automatic logic [OUT_W-1:0] clamp_root(input longint v);
        longint hi;
        hi = (64'sd1 <<< (OUT_W - 1)) - 1;
        if (v > hi)
            v = hi;
        else if (v < -hi - 1)
            v = -hi - 1;
        return v[OUT_W-1:0];
    endfunction

    function automatic solution_t solve_quadratic(input logic signed [15:0] ca,
                                                  input logic signed [15:0] cb,
                                                  input logic signed [15:0] cc);
        longint    a, b, c, disc, nb, den, s;
        solution_t sol;
        a    = ca;
        b    = cb;
        c    = cc;
        disc = b * b - 4 * a * c;
        nb   = -b * (64'sd1 <<< FRAC_BITS);
        den  = 2 * a;
        sol.disc = disc[OUT_W-1:0];
        sol.rp   = '0;
        sol.rm   = '0;
        if (a == 0)
            sol.cls = CLS_AZERO;
        else if (disc < 0)
            sol.cls = CLS_NONE;
        else if (disc == 0)
        begin
            sol.cls = CLS_DOUBLE;
            sol.rp  = clamp_root(nb / den);
            sol.rm  = sol.rp;
        end
        else
        begin
            s = longint'(scaled_isqrt(disc[33:0]));
            sol.cls = CLS_TWO;
            sol.rp  = clamp_root((nb + s) / den);
            sol.rm  = clamp_root((nb - s) / den);
        end
        return sol;
    endfunction

    // hand one coefficient set over, idling in random bursts
    int burst_left;

    task automatic send_set(input logic signed [15:0] a, input logic signed [15:0] b,
                            input logic signed [15:0] c, input solution_t sol);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {c, b, a};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_solutions.push_back(sol);
        n_sent++;
    endtask

    // receiver: stalls on a slowly changing random duty cycle
    int stall_pct;
    int stall_run;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            stall_pct = 0;
            stall_run = 0;
        end
        else
        begin
            if (stall_run == 0)
            begin
                stall_run = $urandom_range(10, 120);
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 20;
                    2:       stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end
            stall_run--;
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        solution_t got;
        solution_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.cls  = m_tuser;
            got.disc = m_tdata[OUT_W-1:0];
            got.rp   = m_tdata[2*OUT_W-1:OUT_W];
            got.rm   = m_tdata[3*OUT_W-1:2*OUT_W];
            if (pending_solutions.size() == 0)
            begin
                $display("%0t: unexpected result cls=%0d disc=%h", $time, got.cls, got.disc);
                errors++;
            end
            else
            begin
                want = pending_solutions.pop_front();
                n_results++;
                class_seen[got.cls]++;
                if (got.cls !== want.cls)
                begin
                    $display("%0t: root_class expected %0d actual %0d",
                             $time, want.cls, got.cls);
                    errors++;
                end
                if (got.disc !== want.disc)
                begin
                    $display("%0t: discriminant expected %h actual %h",
                             $time, want.disc, got.disc);
                    errors++;
                end
                if (got.rp !== want.rp)
                begin
                    $display("%0t: root_plus expected %h actual %h", $time, want.rp, got.rp);
                    errors++;
                end
                if (got.rm !== want.rm)
                begin
                    $display("%0t: root_minus expected %h actual %h",
                             $time, want.rm, got.rm);
                    errors++;
                end
            end
        end
    end

    function automatic logic signed [15:0] rand_coef();
        case ($urandom_range(0, 5))
            0:       return 16'sh7FFF - 16'($urandom_range(0, 2));
            1:       return 16'sh8000 + 16'($urandom_range(0, 2));
            2:       return 16'($signed($urandom_range(0, 16)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    row_t directed[$];

    function automatic row_t mk(input logic signed [15:0] a, input logic signed [15:0] b,
                                input logic signed [15:0] c);
        row_t r;
        r.a = a;
        r.b = b;
        r.c = c;
        r.typed = 1'b0;
        r.sol = '0;
        return r;
    endfunction

    function automatic row_t mk_typed(input logic signed [15:0] a,
                                      input logic signed [15:0] b,
                                      input logic signed [15:0] c,
                                      input logic [CLS_W-1:0] cls,
                                      input longint disc, input longint rp,
                                      input longint rm);
        row_t r;
        r = mk(a, b, c);
        r.typed    = 1'b1;
        r.sol.cls  = cls;
        r.sol.disc = disc[OUT_W-1:0];
        r.sol.rp   = rp[OUT_W-1:0];
        r.sol.rm   = rm[OUT_W-1:0];
        return r;
    endfunction

    initial
    begin
        row_t                r;
        logic signed [15:0]  a, b, c, ra, rb;
        solution_t           sol;
        int                  k;

        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        errors       = 0;
        n_results    = 0;
        n_sent       = 0;
        burst_left   = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // a is zero: discriminant b*b, roots zero
        directed.push_back(mk_typed(0, 0, 0, CLS_AZERO, 0, 0, 0));
        directed.push_back(mk_typed(0, -32768, 5, CLS_AZERO, 64'sd1073741824, 0, 0));
        directed.push_back(mk_typed(0, 32767, -32768, CLS_AZERO, 64'sd1073676289, 0, 0));
        // no real roots
        directed.push_back(mk_typed(1, 0, 1, CLS_NONE, -4, 0, 0));
        directed.push_back(mk_typed(32767, 0, 32767, CLS_NONE, -64'sd4294705156, 0, 0));
        directed.push_back(mk_typed(-32768, 0, -32768, CLS_NONE, -64'sd4294967296, 0, 0));
        // double roots
        directed.push_back(mk_typed(1, -2, 1, CLS_DOUBLE, 0, 65536, 65536));
        directed.push_back(mk_typed(1, 0, 0, CLS_DOUBLE, 0, 0, 0));
        directed.push_back(mk(-1, 2, -1));
        directed.push_back(mk(4, 4, 1));
        // two distinct roots and extremes
        directed.push_back(mk_typed(1, 0, -1, CLS_TWO, 4, 65536, -65536));
        directed.push_back(mk(1, -3, 2));
        directed.push_back(mk(-32768, -32768, 32767));
        directed.push_back(mk(32767, -32768, -32768));
        directed.push_back(mk(-32768, 32767, 32767));
        directed.push_back(mk(1, -32768, 0));
        directed.push_back(mk(-1, 32767, -32768));
        directed.push_back(mk(1, 32767, 1));
        directed.push_back(mk(-32768, -32768, -32768));
        directed.push_back(mk(32767, 32767, 32767));
        directed.push_back(mk(3, 7, -5));
        directed.push_back(mk(-7, 1, 2));

        foreach (directed[i])
        begin
            r   = directed[i];
            sol = r.typed ? r.sol : solve_quadratic(r.a, r.b, r.c);
            if (r.typed && sol !== solve_quadratic(r.a, r.b, r.c))
            begin
                $display("%0t: row %0d typed value disagrees with predictor", $time, i);
                errors++;
            end
            send_set(r.a, r.b, r.c, sol);
        end

        for (k = 0; k < N_RANDOM; k++)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    // integer roots a(x-r1)(x-r2), often double
                    a  = 16'($signed($urandom_range(0, 20)) - 10);
                    ra = 16'($signed($urandom_range(0, 12)) - 6);
                    rb = ($urandom_range(0, 1) == 0) ? ra
                                                     : 16'($signed($urandom_range(0, 12)) - 6);
                    b  = -a * (ra + rb);
                    c  = a * ra * rb;
                end
                1:
                begin
                    a = 0;
                    b = rand_coef();
                    c = rand_coef();
                end
                default:
                begin
                    a = rand_coef();
                    b = rand_coef();
                    c = rand_coef();
                end
            endcase
            send_set(a, b, c, solve_quadratic(a, b, c));
        end
        s_tvalid <= 1'b0;

        while (pending_solutions.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);

        $display("Sent %0d coefficient sets, checked %0d results", n_sent, n_results);
        $display("Classes: none %0d, two %0d, double %0d, a zero %0d",
                 class_seen[0], class_seen[1], class_seen[2], class_seen[3]);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog: ~720 items, worst gaps and 90% stalls stay well under this
    initial
    begin
        #2000000;
        $display("Timeout with %0d results outstanding", pending_solutions.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
